FILE: design/npos_pkg.sv
package npos_pkg;

    typedef enum logic [1:0] {
        REGION_END      = 2'd0,
        REGION_START    = 2'd1,
        REGION_INTERIOR = 2'd2
    } region_t;

    typedef enum logic [1:0] {
        CFG_START_X = 2'd0,
        CFG_START_Y = 2'd1,
        CFG_END_X   = 2'd2,
        CFG_END_Y   = 2'd3
    } cfg_index_t;

endpackage

FILE: design/npos_dot.sv
module npos_dot #(
    parameter int W = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic signed [W-1:0]   ref_x,
    input  logic signed [W-1:0]   ref_y,
    input  logic signed [W-1:0]   start_x,
    input  logic signed [W-1:0]   start_y,
    input  logic signed [W-1:0]   end_x,
    input  logic signed [W-1:0]   end_y,
    output logic                  out_valid,
    output logic signed [2*W+2:0] e_sum,
    output logic signed [2*W+2:0] n_sum,
    output logic signed [2*W+2:0] q_sum,
    output logic signed [W:0]     dx_out,
    output logic signed [W:0]     dy_out
);
    localparam int D  = W + 1;
    localparam int P2 = 2 * D;
    localparam int S  = 2 * D + 1;

    logic                  v1_reg, v2_reg, v3_reg;
    logic signed [D-1:0]   dx1_reg, dy1_reg, uex_reg, uey_reg, usx_reg, usy_reg;
    logic signed [D-1:0]   dx2_reg, dy2_reg, dx3_reg, dy3_reg;
    logic signed [P2-1:0]  pex_reg, pey_reg, pnx_reg, pny_reg, pqx_reg, pqy_reg;
    logic signed [S-1:0]   e_reg, n_reg, q_reg;

    logic signed [D-1:0]   dx1_next, dy1_next, uex_next, uey_next, usx_next, usy_next;

    // differences against both end points
    assign dx1_next = D'(end_x) - D'(start_x);
    assign dy1_next = D'(end_y) - D'(start_y);
    assign uex_next = D'(ref_x) - D'(end_x);
    assign uey_next = D'(ref_y) - D'(end_y);
    assign usx_next = D'(ref_x) - D'(start_x);
    assign usy_next = D'(ref_y) - D'(start_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx1_reg <= dx1_next;
            dy1_reg <= dy1_next;
            uex_reg <= uex_next;
            uey_reg <= uey_next;
            usx_reg <= usx_next;
            usy_reg <= usy_next;

            pex_reg <= P2'(dx1_reg) * P2'(uex_reg);
            pey_reg <= P2'(dy1_reg) * P2'(uey_reg);
            pnx_reg <= P2'(dx1_reg) * P2'(usx_reg);
            pny_reg <= P2'(dy1_reg) * P2'(usy_reg);
            pqx_reg <= P2'(dx1_reg) * P2'(dx1_reg);
            pqy_reg <= P2'(dy1_reg) * P2'(dy1_reg);
            dx2_reg <= dx1_reg;
            dy2_reg <= dy1_reg;

            e_reg   <= S'(pex_reg) + S'(pey_reg);
            n_reg   <= S'(pnx_reg) + S'(pny_reg);
            q_reg   <= S'(pqx_reg) + S'(pqy_reg);
            dx3_reg <= dx2_reg;
            dy3_reg <= dy2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign e_sum     = e_reg;
    assign n_sum     = n_reg;
    assign q_sum     = q_reg;
    assign dx_out    = dx3_reg;
    assign dy_out    = dy3_reg;

endmodule

FILE: design/npos_scale.sv
module npos_scale #(
    parameter int W = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic signed [2*W+2:0] e_sum,
    input  logic signed [2*W+2:0] n_sum,
    input  logic signed [2*W+2:0] q_sum,
    input  logic signed [W:0]     dx,
    input  logic signed [W:0]     dy,
    output logic                  out_valid,
    output npos_pkg::region_t     region,
    output logic                  neg_x,
    output logic                  neg_y,
    output logic [3*W:0]          num_x,
    output logic [3*W:0]          num_y,
    output logic [2*W:0]          den
);
    import npos_pkg::*;

    localparam int NW = 2 * W + 1;
    localparam int PL = 2 * W + 1;
    localparam int PH = 2 * W;
    localparam int PW = 3 * W + 1;

    logic            v4_reg, v5_reg;
    region_t         reg4_reg, reg5_reg;
    logic            nx4_reg, ny4_reg, nx5_reg, ny5_reg;
    logic [PL-1:0]   pxl_reg, pyl_reg;
    logic [PH-1:0]   pxh_reg, pyh_reg;
    logic [NW-1:0]   q4_reg, q5_reg;
    logic [PW-1:0]   numx_reg, numy_reg;

    region_t         reg4_next;
    logic [W-1:0]    ax, ay;
    logic [NW-1:0]   nn;
    logic [W:0]      nlo;
    logic [W-1:0]    nhi;
    logic signed [W:0] negdx, negdy;

    always_comb begin
        if (!e_sum[2*W+2]) begin
            reg4_next = REGION_END;
        end else if (n_sum[2*W+2] || (n_sum == '0)) begin
            reg4_next = REGION_START;
        end else begin
            reg4_next = REGION_INTERIOR;
        end
    end

    // |d| stays below 2^W, n below 2^(2W+1) on the interior path
    assign negdx = -dx;
    assign negdy = -dy;
    assign ax    = dx[W] ? negdx[W-1:0] : dx[W-1:0];
    assign ay    = dy[W] ? negdy[W-1:0] : dy[W-1:0];
    assign nn    = n_sum[NW-1:0];
    assign nlo   = nn[W:0];
    assign nhi   = nn[NW-1:W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            reg4_reg <= reg4_next;
            nx4_reg  <= dx[W];
            ny4_reg  <= dy[W];
            pxl_reg  <= PL'(ax) * PL'(nlo);
            pxh_reg  <= PH'(ax) * PH'(nhi);
            pyl_reg  <= PL'(ay) * PL'(nlo);
            pyh_reg  <= PH'(ay) * PH'(nhi);
            q4_reg   <= q_sum[NW-1:0];

            reg5_reg <= reg4_reg;
            nx5_reg  <= nx4_reg;
            ny5_reg  <= ny4_reg;
            numx_reg <= PW'(pxl_reg) + (PW'(pxh_reg) << (W + 1));
            numy_reg <= PW'(pyl_reg) + (PW'(pyh_reg) << (W + 1));
            q5_reg   <= q4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign region    = reg5_reg;
    assign neg_x     = nx5_reg;
    assign neg_y     = ny5_reg;
    assign num_x     = numx_reg;
    assign num_y     = numy_reg;
    assign den       = q5_reg;

endmodule

FILE: design/npos_div.sv
module npos_div #(
    parameter int W  = 32,
    parameter int TW = 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [3*W:0]    in_num,
    input  logic [2*W:0]    in_den,
    input  logic [TW-1:0]   in_tag,
    output logic            out_valid,
    output logic [W:0]      out_quot,
    output logic [TW-1:0]   out_tag
);
    localparam int PW = 3 * W + 1;
    localparam int NW = 2 * W + 1;
    localparam int RW = 3 * W + 2;

    logic            v_reg   [W];
    logic [PW-1:0]   rem_reg [W];
    logic [W-1:0]    quo_reg [W];
    logic [NW-1:0]   den_reg [W];
    logic [TW-1:0]   tag_reg [W];

    logic            vo_reg;
    logic [W:0]      quot_reg;
    logic [TW-1:0]   tago_reg;
    logic            rnd;

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < W; k++) begin : g_stage
        logic            v_in;
        logic [PW-1:0]   rem_in, rem_next;
        logic [W-1:0]    quo_in, quo_next;
        logic [NW-1:0]   den_in;
        logic [TW-1:0]   tag_in;
        logic [RW-1:0]   trial;
        logic            take;

        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign rem_in = in_num;
            assign quo_in = '0;
            assign den_in = in_den;
            assign tag_in = in_tag;
        end else begin : g_rest
            assign v_in   = v_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign den_in = den_reg[k-1];
            assign tag_in = tag_reg[k-1];
        end

        assign trial = RW'(den_in) << (W - 1 - k);
        assign take  = RW'(rem_in) >= trial;

        always_comb begin
            quo_next           = quo_in;
            quo_next[W-1-k]    = take;
            rem_next           = take ? (rem_in - trial[PW-1:0]) : rem_in;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (adv) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
                den_reg[k] <= den_in;
                tag_reg[k] <= tag_in;
            end
        end
    end

    // round half away from zero on the magnitude
    assign rnd = {rem_reg[W-1][NW-1:0], 1'b0} >= {1'b0, den_reg[W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (adv) begin
            vo_reg <= v_reg[W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            quot_reg <= (W+1)'(quo_reg[W-1]) + (W+1)'(rnd);
            tago_reg <= tag_reg[W-1];
        end
    end

    assign out_valid = vo_reg;
    assign out_quot  = quot_reg;
    assign out_tag   = tago_reg;

endmodule

FILE: design/nearest_point_on_segment_unit.sv
// Nearest point on a 2-D segment. The segment ends are written over the APB
// port (start_x, start_y, end_x, end_y at word offsets 0..3, stride 8 bytes
// when COORD_WIDTH exceeds 32), each query point enters on the s_ stream and
// the nearest segment point leaves on the m_ stream with a region code in
// m_tuser: end clamp, start clamp or interior projection. The pipeline takes
// one query every cycle while it is not held; the divider resolves one
// quotient bit per stage on each axis. The whole pipeline advances together:
// it holds only while a result sits unaccepted in the output register. Write
// the segment only while no query is in flight.
module nearest_point_on_segment_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // APB configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [((COORD_WIDTH > 32) ? 5 : 4)-1:0]  paddr,
    input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
    output logic                   pready,
    // query stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata: ref_x, ref_y, zero pad
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata: near_x, near_y, zero pad
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    // m_tuser: region
    output logic [1:0]             m_tuser
);
    import npos_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int AW  = (W > 32) ? 5 : 4;
    localparam int DW  = (W > 32) ? 64 : 32;
    localparam int TDW = ((2 * W + 7) / 8) * 8;
    localparam int SW  = W + 2;

    // signed coordinate limits at the widened sum width
    localparam logic signed [SW-1:0] NEAR_MAX = $signed(SW'({1'b0, {(W-1){1'b1}}}));
    localparam logic signed [SW-1:0] NEAR_MIN = ~NEAR_MAX;

    logic signed [W-1:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    cfg_index_t          cfg_idx;
    logic                cfg_wr;

    logic                adv;

    logic                dot_valid;
    logic signed [2*W+2:0] e_sum, n_sum, q_sum;
    logic signed [W:0]   dx, dy;

    logic                sc_valid;
    region_t             sc_region;
    logic                sc_neg_x, sc_neg_y;
    logic [3*W:0]        num_x, num_y;
    logic [2*W:0]        den;

    logic                divx_valid, divy_valid;
    logic [W:0]          quot_x, quot_y;
    logic [2:0]          tag_x;
    logic [0:0]          tag_y;
    region_t             div_region;

    logic signed [SW-1:0] delta_x, delta_y, sum_x, sum_y;
    logic signed [W-1:0]  near_x_next, near_y_next;

    logic                m_valid_reg;
    logic [W-1:0]        near_x_reg, near_y_reg;
    region_t             region_reg;

    // configuration: write on the access phase, read back zero-extended
    assign pready  = 1'b1;
    assign cfg_idx = cfg_index_t'(paddr[AW-1:AW-2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                CFG_START_X: start_x_reg <= pwdata[W-1:0];
                CFG_START_Y: start_y_reg <= pwdata[W-1:0];
                CFG_END_X:   end_x_reg   <= pwdata[W-1:0];
                CFG_END_Y:   end_y_reg   <= pwdata[W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            CFG_START_X: prdata = DW'(unsigned'(start_x_reg));
            CFG_START_Y: prdata = DW'(unsigned'(start_y_reg));
            CFG_END_X:   prdata = DW'(unsigned'(end_x_reg));
            CFG_END_Y:   prdata = DW'(unsigned'(end_y_reg));
            default:     prdata = '0;
        endcase
    end

    // advance every stage together unless the output transaction is stuck
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    npos_dot #(.W(W)) u_dot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .ref_x     ($signed(s_tdata[W-1:0])),
        .ref_y     ($signed(s_tdata[2*W-1:W])),
        .start_x   (start_x_reg),
        .start_y   (start_y_reg),
        .end_x     (end_x_reg),
        .end_y     (end_y_reg),
        .out_valid (dot_valid),
        .e_sum     (e_sum),
        .n_sum     (n_sum),
        .q_sum     (q_sum),
        .dx_out    (dx),
        .dy_out    (dy)
    );

    npos_scale #(.W(W)) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (dot_valid),
        .e_sum     (e_sum),
        .n_sum     (n_sum),
        .q_sum     (q_sum),
        .dx        (dx),
        .dy        (dy),
        .out_valid (sc_valid),
        .region    (sc_region),
        .neg_x     (sc_neg_x),
        .neg_y     (sc_neg_y),
        .num_x     (num_x),
        .num_y     (num_y),
        .den       (den)
    );

    // x lane carries the region code alongside its sign
    npos_div #(.W(W), .TW(3)) u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (sc_valid),
        .in_num    (num_x),
        .in_den    (den),
        .in_tag    ({sc_region, sc_neg_x}),
        .out_valid (divx_valid),
        .out_quot  (quot_x),
        .out_tag   (tag_x)
    );

    npos_div #(.W(W), .TW(1)) u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (sc_valid),
        .in_num    (num_y),
        .in_den    (den),
        .in_tag    (sc_neg_y),
        .out_valid (divy_valid),
        .out_quot  (quot_y),
        .out_tag   (tag_y)
    );

    assign div_region = region_t'(tag_x[2:1]);

    // interior: apply the sign, offset from the start point, then clamp to range; clamps take an end point
    assign delta_x = tag_x[0] ? -$signed(SW'(quot_x)) : $signed(SW'(quot_x));
    assign delta_y = tag_y[0] ? -$signed(SW'(quot_y)) : $signed(SW'(quot_y));
    assign sum_x   = SW'(start_x_reg) + delta_x;
    assign sum_y   = SW'(start_y_reg) + delta_y;

    always_comb begin
        case (div_region)
            REGION_END: begin
                near_x_next = end_x_reg;
                near_y_next = end_y_reg;
            end
            REGION_START: begin
                near_x_next = start_x_reg;
                near_y_next = start_y_reg;
            end
            default: begin
                if (sum_x > NEAR_MAX)
                    near_x_next = NEAR_MAX[W-1:0];
                else if (sum_x < NEAR_MIN)
                    near_x_next = NEAR_MIN[W-1:0];
                else
                    near_x_next = sum_x[W-1:0];
                if (sum_y > NEAR_MAX)
                    near_y_next = NEAR_MAX[W-1:0];
                else if (sum_y < NEAR_MIN)
                    near_y_next = NEAR_MIN[W-1:0];
                else
                    near_y_next = sum_y[W-1:0];
            end
        endcase
    end

    // output register: the last pipeline stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= divx_valid && divy_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            near_x_reg <= near_x_next;
            near_y_reg <= near_y_next;
            region_reg <= div_region;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDW'({near_y_reg, near_x_reg});
    assign m_tuser  = region_reg;

endmodule

FILE: tb/nearest_point_on_segment_unit_test.sv
`timescale 1ns / 100ps

module nearest_point_on_segment_unit_test;
    import npos_pkg::*;

    localparam int CW      = 32;
    localparam int LATENCY = CW + 7;
    localparam int STALL_LIMIT = 4000;
    localparam logic signed [31:0] MAXC = 32'sh7fffffff;
    localparam logic signed [31:0] MINC = 32'sh80000000;

    typedef struct packed {
        logic signed [31:0] y;
        logic signed [31:0] x;
    } point_t;

    typedef struct {
        logic signed [31:0] near_x;
        logic signed [31:0] near_y;
        region_t            region;
    } nearest_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    nearest_point_on_segment_unit #(.COORD_WIDTH(CW)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #6 aclk = ~aclk;

    // Local copy of the segment registers
    logic signed [31:0] seg_sx = 0, seg_sy = 0, seg_ex = 0, seg_ey = 0;

    point_t   query_queue[$];
    nearest_t nearest_queue[$];

    int  n_failures = 0;
    int  n_checked  = 0;
    int  n_region[3] = '{0, 0, 0};
    bit  calm     = 1'b0;  // no idling on either side
    bit  hold_off = 1'b0;  // receiver stall request
    int  idle_cycles = 0;

    // Round p/den to nearest, ties away from zero; den > 0
    function automatic logic signed [63:0] round_div(logic signed [191:0] p,
                                                     logic signed [191:0] den);
        logic signed [191:0] mag, quo, rem;
        mag = (p < 0) ? -p : p;
        quo = mag / den;
        rem = mag - quo * den;
        if (2 * rem >= den) quo = quo + 1;
        return (p < 0) ? -quo[63:0] : quo[63:0];
    endfunction

    function automatic logic signed [31:0] clamp_coord(logic signed [63:0] v);
        if (v > 64'(MAXC)) return MAXC;
        if (v < 64'(MINC)) return MINC;
        return v[31:0];
    endfunction

    function automatic nearest_t project_point(point_t r);
        nearest_t res;
        logic signed [63:0]  dx, dy, rx, ry, sx, sy, ex, ey;
        logic signed [191:0] dot_end, n, q;
        sx = seg_sx; sy = seg_sy; ex = seg_ex; ey = seg_ey;
        rx = r.x; ry = r.y;
        dx = ex - sx; dy = ey - sy;
        dot_end = 192'(dx) * 192'(rx - ex) + 192'(dy) * 192'(ry - ey);
        if (dot_end >= 0) begin
            res.near_x = clamp_coord(ex); res.near_y = clamp_coord(ey);
            res.region = REGION_END;
            return res;
        end
        n = 192'(dx) * 192'(rx - sx) + 192'(dy) * 192'(ry - sy);
        if (n <= 0) begin
            res.near_x = clamp_coord(sx); res.near_y = clamp_coord(sy);
            res.region = REGION_START;
            return res;
        end
        q = 192'(dx) * 192'(dx) + 192'(dy) * 192'(dy);
        res.near_x = clamp_coord(sx + round_div(192'(dx) * n, q));
        res.near_y = clamp_coord(sy + round_div(192'(dy) * n, q));
        res.region = REGION_INTERIOR;
        return res;
    endfunction

    // Driver: offer queued points, predict at each accepted transaction
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            nearest_queue.push_back(project_point(point_t'(s_tdata)));
            void'(query_queue.pop_front());
        end
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
            // hold the offered transaction
        end else begin
            // the front of the queue is always the next point not yet sent
            if (query_queue.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= query_queue[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            nearest_t want;
            point_t   got;
            got = point_t'(m_tdata);
            if (nearest_queue.size() == 0) begin
                $error("unexpected result x=%0d y=%0d region=%0d", got.x, got.y, m_tuser);
                n_failures++;
            end else begin
                want = nearest_queue.pop_front();
                n_checked++;
                if (got.x !== want.near_x) begin
                    $error("near_x: expected %0d, got %0d", want.near_x, got.x);
                    n_failures++;
                end
                if (got.y !== want.near_y) begin
                    $error("near_y: expected %0d, got %0d", want.near_y, got.y);
                    n_failures++;
                end
                if (m_tuser !== want.region) begin
                    $error("region: expected %0d, got %0d", want.region, m_tuser);
                    n_failures++;
                end else begin
                    n_region[want.region]++;
                end
            end
        end
        if (!aresetn || hold_off) m_tready <= 1'b0;
        else m_tready <= calm || ($urandom_range(99) >= 29);
    end

    // Watchdog: count cycles with no accepted transaction on either stream, outside reset and hold_off
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout waiting for a transaction");
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic apb_write(cfg_index_t idx, logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 4'(idx) << 2; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            CFG_START_X: seg_sx = value;
            CFG_START_Y: seg_sy = value;
            CFG_END_X:   seg_ex = value;
            CFG_END_Y:   seg_ey = value;
            default: ;
        endcase
    endtask

    task automatic set_segment(logic [31:0] sx, logic [31:0] sy,
                               logic [31:0] ex, logic [31:0] ey);
        apb_write(CFG_START_X, sx);
        apb_write(CFG_START_Y, sy);
        apb_write(CFG_END_X, ex);
        apb_write(CFG_END_Y, ey);
    endtask

    // Wait until every query has come back, then let the pipe drain
    task automatic drain;
        while (query_queue.size() != 0 || s_tvalid || nearest_queue.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
            default: return 32'($signed($urandom_range(200000)) - 100000);
        endcase
    endfunction

    // Mostly points near the segment so all three regions turn up
    function automatic point_t near_segment_point;
        point_t p;
        logic signed [63:0] t;
        int mode;
        mode = $urandom_range(9);
        if (mode == 0) begin
            p.x = $urandom(); p.y = $urandom();
        end else begin
            t = $signed($urandom_range(1400)) - 200;
            p.x = clamp_coord(64'(seg_sx) + (64'(seg_ex) - 64'(seg_sx)) * t / 1000
                              + $signed($urandom_range(4000)) - 2000);
            p.y = clamp_coord(64'(seg_sy) + (64'(seg_ey) - 64'(seg_sy)) * t / 1000
                              + $signed($urandom_range(4000)) - 2000);
        end
        return p;
    endfunction

    initial begin
        point_t p;
        int phase_items;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset segment is degenerate: everything clamps to the end point
        query_queue.push_back('{x: MAXC, y: MINC});
        query_queue.push_back('{x: 32'sd0, y: 32'sd0});
        drain();

        // Directed: a horizontal segment, both clamps, interior and a tie
        set_segment(32'h0000_0000, 32'h0000_0000, 32'h000a_0000, 32'h0000_0000);
        query_queue.push_back('{x: 32'h000b_0000, y: 32'h0001_0000});
        query_queue.push_back('{x: 32'h000a_0000, y: 32'hffff_0000});
        query_queue.push_back('{x: 32'hffff_0000, y: 32'h0003_0000});
        query_queue.push_back('{x: 32'h0000_0000, y: 32'h0005_0000});
        query_queue.push_back('{x: 32'h0004_8000, y: MAXC});
        query_queue.push_back('{x: 32'h0000_0001, y: MINC});
        drain();
        // Diagonal with rounding, then full range extremes
        set_segment(32'h0000_0000, 32'h0000_0000, 32'h0000_0003, 32'h0000_0001);
        query_queue.push_back('{x: 32'sd1, y: 32'sd0});
        query_queue.push_back('{x: 32'sd2, y: 32'sd1});
        query_queue.push_back('{x: -32'sd1, y: 32'sd5});
        drain();
        set_segment(MINC, MINC, MAXC, MAXC);
        query_queue.push_back('{x: MAXC, y: MINC});
        query_queue.push_back('{x: MINC, y: MAXC});
        query_queue.push_back('{x: 32'sd0, y: 32'sd0});
        query_queue.push_back('{x: MAXC, y: MAXC});
        query_queue.push_back('{x: MINC, y: MINC});
        query_queue.push_back('{x: 32'sd1, y: -32'sd1});
        drain();
        set_segment(MAXC, MINC, MINC, MAXC);
        query_queue.push_back('{x: 32'h5555_5555, y: 32'haaaa_aaaa});
        query_queue.push_back('{x: 32'h1234_5678, y: 32'h0000_0000});
        drain();

        // Random phases, each with a fresh segment
        for (int ph = 0; ph < 12; ph++) begin
            int mode;
            mode = ph % 3;
            if (ph == 5) set_segment(32'h0001_0000, 32'h0002_0000,
                                     32'h0001_0000, 32'h0002_0000);
            else set_segment(rand_coord(mode), rand_coord(mode),
                             rand_coord(mode), rand_coord(mode));
            calm = (ph == 3);
            phase_items = 75;
            for (int i = 0; i < phase_items; i++) begin
                query_queue.push_back(near_segment_point());
                if (ph == 7 && i == 10) begin
                    // Stall the receiver so the pipeline fills and backs up
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (3 * LATENCY) @(posedge aclk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
            end
            // Sender pauses here until every expected result has come
            drain();
        end
        calm = 1'b0;

        $display("checked %0d results: %0d end clamps, %0d start clamps, %0d interior",
                 n_checked, n_region[0], n_region[1], n_region[2]);
        $display("segments covered extremes, degenerate, diagonal and random spans");
        if (n_failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

FILE: filelist.f
design/npos_pkg.sv
design/npos_dot.sv
design/npos_scale.sv
design/npos_div.sv
design/nearest_point_on_segment_unit.sv
tb/nearest_point_on_segment_unit_test.sv
